// ===== src/sthm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sthm_pkg
// Types and constants shared by the open-addressing hash table modules.
// ----------------------------------------------------------------------------
package sthm_pkg;

   localparam int unsigned CAPACITY   = 1024;
   localparam int unsigned GROUP_SIZE = 8;
   localparam int unsigned KEY_BITS   = 64;
   localparam int unsigned VALUE_BITS = 64;

   localparam int unsigned SLOT_BITS  = $clog2(CAPACITY);
   localparam int unsigned GRP_BITS   = $clog2(GROUP_SIZE);
   localparam int unsigned NUM_GROUPS = CAPACITY / GROUP_SIZE;
   localparam int unsigned GCNT_BITS  = $clog2(NUM_GROUPS + 1);
   localparam int unsigned COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int unsigned FULL_LIMIT = (CAPACITY / 8) * 7;

   localparam logic [7:0] TAG_FRAG    = 8'h7F;
   localparam logic [7:0] TAG_DELETED = 8'b11111110;
   localparam logic [7:0] TAG_EMPTY   = 8'b11111111;

   typedef enum logic [1:0] {
      FUNC_FIND    = 2'd0,
      FUNC_INSERT  = 2'd1,
      FUNC_REPLACE = 2'd2,
      FUNC_DELETE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_UPDATED   = 3'd3,
      ST_EXISTING  = 3'd4,
      ST_DELETED   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [31:0] hash;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] result_value;
      logic [9:0]  slot;
      logic [10:0] entry_count;
   } rsp_type;

   // Classified operation as passed from the front part to the back part.
   typedef struct packed {
      func_type               func;
      logic [KEY_BITS-1:0]    key;
      logic [6:0]             frag;
      logic [SLOT_BITS-1:0]   home;
      logic [VALUE_BITS-1:0]  value;
   } op_type;

endpackage
`default_nettype wire

// ===== src/sthm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sthm_front
// Accepts request items, splits the hash and queues classified operations.
// ----------------------------------------------------------------------------
module sthm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sthm_pkg::req_type req_data,
   output logic                  op_valid,
   input  wire logic             op_take,
   output sthm_pkg::op_type      op_data
);

   localparam int unsigned QDEPTH = 2;

   sthm_pkg::op_type q_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   sthm_pkg::op_type op_new;
   logic             push, pop;

   always_comb begin
      op_new.func  = sthm_pkg::func_type'(req_data.func);
      op_new.key   = req_data.key[sthm_pkg::KEY_BITS-1:0];
      op_new.frag  = req_data.hash[6:0];
      op_new.home  = req_data.hash[7 +: sthm_pkg::SLOT_BITS];
      op_new.value = req_data.value[sthm_pkg::VALUE_BITS-1:0];
   end

   assign req_stall = (cnt_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign op_valid  = (cnt_ff != 2'd0);
   assign pop       = op_valid && op_take;
   assign op_data   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule
`default_nettype wire

// ===== src/sthm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sthm_back
// Probes the slot memories one slot at a time, through a read and a check state, and applies each operation.
// ----------------------------------------------------------------------------
module sthm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   output logic                   op_take,
   input  wire sthm_pkg::op_type  op_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sthm_pkg::rsp_type      rsp_data
);

   localparam int unsigned SB = sthm_pkg::SLOT_BITS;
   localparam int unsigned GB = sthm_pkg::GRP_BITS;
   localparam int unsigned CB = sthm_pkg::COUNT_BITS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_APPLY, S_RESP
   } state_type;

   logic [7:0]                     tag_mem [sthm_pkg::CAPACITY];
   logic [sthm_pkg::KEY_BITS-1:0]   key_mem [sthm_pkg::CAPACITY];
   logic [sthm_pkg::VALUE_BITS-1:0] val_mem [sthm_pkg::CAPACITY];

   state_type                   state_ff;
   sthm_pkg::op_type            op_ff;
   logic [SB-1:0]               base_ff;
   logic [SB-1:0]               step_ff;
   logic [GB-1:0]               idx_ff;
   logic [sthm_pkg::GCNT_BITS-1:0] grp_ff;
   logic [SB-1:0]               addr_ff;
   logic [SB:0]                 clr_ff;
   logic                        have_del_ff;
   logic [SB-1:0]               del_at_ff;
   logic [CB-1:0]               count_ff;
   logic [7:0]                  tag_rd_ff;
   logic [sthm_pkg::KEY_BITS-1:0]   key_rd_ff;
   logic [sthm_pkg::VALUE_BITS-1:0] val_rd_ff;
   sthm_pkg::rsp_type           rsp_ff;

   // Write request, set by the check and apply states.
   logic                        wr_tag_ff, wr_key_ff, wr_val_ff;
   logic [SB-1:0]               wr_addr_ff;
   logic [7:0]                  wr_tag_data_ff;

   logic [SB-1:0] slot_addr;
   logic          last_grp, is_ins, tag_hit;

   assign slot_addr = base_ff + SB'(idx_ff);
   assign is_ins    = (op_ff.func == sthm_pkg::FUNC_INSERT) ||
                      (op_ff.func == sthm_pkg::FUNC_REPLACE);
   assign last_grp  = (grp_ff == sthm_pkg::GCNT_BITS'(sthm_pkg::NUM_GROUPS - 1));
   assign tag_hit   = (tag_rd_ff == {1'b0, op_ff.frag}) && (key_rd_ff == op_ff.key);
   assign op_take   = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      tag_rd_ff <= tag_mem[addr_ff];
      key_rd_ff <= key_mem[addr_ff];
      val_rd_ff <= val_mem[addr_ff];
      if (state_ff == S_CLEAR) begin
         tag_mem[clr_ff[SB-1:0]] <= sthm_pkg::TAG_EMPTY;
      end else if (wr_tag_ff) begin
         tag_mem[wr_addr_ff] <= wr_tag_data_ff;
      end
      if (wr_key_ff) begin
         key_mem[wr_addr_ff] <= op_ff.key;
      end
      if (wr_val_ff) begin
         val_mem[wr_addr_ff] <= op_ff.value;
      end
   end

   task automatic finish(input sthm_pkg::status_type st,
                         input logic [sthm_pkg::VALUE_BITS-1:0] rv,
                         input logic [SB-1:0] sl,
                         input logic [CB-1:0] cnt);
      rsp_ff.status       <= st;
      rsp_ff.result_value <= 64'(rv);
      rsp_ff.slot         <= 10'(sl);
      rsp_ff.entry_count  <= 11'(cnt);
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         count_ff  <= '0;
         wr_tag_ff <= 1'b0;
         wr_key_ff <= 1'b0;
         wr_val_ff <= 1'b0;
      end else begin
         wr_tag_ff <= 1'b0;
         wr_key_ff <= 1'b0;
         wr_val_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (SB+1)'(sthm_pkg::CAPACITY - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (op_valid) begin
                  op_ff       <= op_data;
                  base_ff     <= op_data.home;
                  step_ff     <= SB'(sthm_pkg::GROUP_SIZE);
                  idx_ff      <= '0;
                  grp_ff      <= '0;
                  addr_ff     <= op_data.home;
                  have_del_ff <= 1'b0;
                  del_at_ff   <= '0;
                  if (((op_data.func == sthm_pkg::FUNC_INSERT) ||
                       (op_data.func == sthm_pkg::FUNC_REPLACE)) &&
                      (count_ff >= CB'(sthm_pkg::FULL_LIMIT))) begin
                     finish(sthm_pkg::ST_FULL, '0, '0, count_ff);
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               priority if (tag_rd_ff == sthm_pkg::TAG_EMPTY) begin
                  if (is_ins) begin
                     wr_addr_ff     <= have_del_ff ? del_at_ff : addr_ff;
                     state_ff       <= S_APPLY;
                  end else begin
                     finish(sthm_pkg::ST_NOT_FOUND, '0, '0, count_ff);
                     state_ff <= S_RESP;
                  end
               end else if (tag_hit) begin
                  unique case (op_ff.func)
                     sthm_pkg::FUNC_FIND: begin
                        finish(sthm_pkg::ST_FOUND, val_rd_ff, addr_ff, count_ff);
                     end
                     sthm_pkg::FUNC_INSERT: begin
                        finish(sthm_pkg::ST_EXISTING, val_rd_ff, addr_ff, count_ff);
                     end
                     sthm_pkg::FUNC_REPLACE: begin
                        wr_addr_ff <= addr_ff;
                        wr_val_ff  <= 1'b1;
                        finish(sthm_pkg::ST_UPDATED, '0, addr_ff, count_ff);
                     end
                     sthm_pkg::FUNC_DELETE: begin
                        wr_addr_ff     <= addr_ff;
                        wr_tag_ff      <= 1'b1;
                        wr_tag_data_ff <= sthm_pkg::TAG_DELETED;
                        count_ff       <= count_ff - 1'b1;
                        finish(sthm_pkg::ST_DELETED, '0, addr_ff, count_ff - 1'b1);
                     end
                     default: ;
                  endcase
                  state_ff <= S_RESP;
               end else begin
                  if ((tag_rd_ff == sthm_pkg::TAG_DELETED) && !have_del_ff) begin
                     have_del_ff <= 1'b1;
                     del_at_ff   <= addr_ff;
                  end
                  if (idx_ff == GB'(sthm_pkg::GROUP_SIZE - 1)) begin
                     if (last_grp) begin
                        if (is_ins && (have_del_ff ||
                            (tag_rd_ff == sthm_pkg::TAG_DELETED))) begin
                           wr_addr_ff <= have_del_ff ? del_at_ff : addr_ff;
                           state_ff   <= S_APPLY;
                        end else begin
                           finish(is_ins ? sthm_pkg::ST_FULL : sthm_pkg::ST_NOT_FOUND,
                                  '0, '0, count_ff);
                           state_ff <= S_RESP;
                        end
                     end else begin
                        base_ff  <= base_ff + step_ff;
                        step_ff  <= step_ff + SB'(sthm_pkg::GROUP_SIZE);
                        grp_ff   <= grp_ff + 1'b1;
                        idx_ff   <= '0;
                        addr_ff  <= base_ff + step_ff;
                        state_ff <= S_READ;
                     end
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     addr_ff  <= slot_addr + 1'b1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_APPLY: begin
               wr_tag_ff      <= 1'b1;
               wr_key_ff      <= 1'b1;
               wr_val_ff      <= 1'b1;
               wr_tag_data_ff <= {1'b0, op_ff.frag};
               count_ff       <= count_ff + 1'b1;
               finish(sthm_pkg::ST_INSERTED, '0, wr_addr_ff, count_ff + 1'b1);
               state_ff       <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/swiss_table_hash_map_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swiss_table_hash_map_unit
// Open-addressing key/value table with a control tag per slot.
// ----------------------------------------------------------------------------
//  Channel  Ports                      Direction  Item
//  req      req_valid/stall/data       in         func, key, hash, value
//  rsp      rsp_valid/stall/data       out        status, value, slot, count
//
//  Each item goes through the back part's idle state, a read and a check state
//  per slot probed in its slot memories, an apply state when an insert writes
//  a new entry, and the response state; a full-table reject goes from idle to
//  the response state. After reset a clearing pass sets every tag to empty;
//  the two-entry front queue accepts up to two items meanwhile.
//  A stalled response holds the back part; the front queue accepts until full.
// ----------------------------------------------------------------------------
module swiss_table_hash_map_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sthm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sthm_pkg::rsp_type      rsp_data
);

   logic             op_valid, op_take;
   sthm_pkg::op_type op_data;

   sthm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .op_valid, .op_take, .op_data
   );

   sthm_back u_back (
      .clock, .reset, .op_valid, .op_take, .op_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
`default_nettype wire

// ===== src/sthm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sthm_checker
// Port-level checks for the hash table unit.
// ----------------------------------------------------------------------------
module sthm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire sthm_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire sthm_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled item changed.");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 11'(sthm_pkg::FULL_LIMIT))
      else $error("Entry count beyond limit.");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 3'd7)
      else $error("Bad status.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == sthm_pkg::ST_NOT_FOUND ||
                    rsp_data.status == sthm_pkg::ST_FULL)
      |-> rsp_data.slot == 10'd0 && rsp_data.result_value == 64'd0)
      else $error("Miss with nonzero fields.");

endmodule

bind swiss_table_hash_map_unit sthm_checker u_checker (.*);
`default_nettype wire
